@@ rtl/core/spectral_peak_detector_unit_defines.svh @@
// ---------------------------------------------------------------------------
// Spectral peak detector assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef SPECTRAL_PEAK_DETECTOR_UNIT_DEFINES_SVH
`define SPECTRAL_PEAK_DETECTOR_UNIT_DEFINES_SVH

// A condition that holds at every clock edge out of reset.
`define SPD_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// A consequence that holds in the same cycle as its antecedent.
`define SPD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// A consequence that holds in the cycle after its antecedent.
`define SPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/spd_pkg.sv @@
// ---------------------------------------------------------------------------
// Spectral peak detector package
// Field widths, register codes and reset values of the peak detector.
// ---------------------------------------------------------------------------
package spd_pkg;

  // Parameter defaults.
  localparam int unsigned MAX_BINS_DEFAULT     = 4096;
  localparam int unsigned SAMPLE_WIDTH_DEFAULT = 24;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BINS_PER_FRAME  = 2'd0,
    CFG_RATIO_THRESHOLD = 2'd1,
    CFG_BIN_STEP        = 2'd2
  } cfg_reg_e;

  // Register widths and reset values.
  localparam int unsigned BINS_CFG_W = 13;
  localparam int unsigned RATIO_W    = 16;
  localparam int unsigned STEP_W     = 24;

  localparam logic [BINS_CFG_W-1:0] BINS_RESET  = 13'd2048;
  localparam logic [RATIO_W-1:0]    RATIO_RESET = 16'd200;
  localparam logic [STEP_W-1:0]     STEP_RESET  = 24'd2560;

  // Result fields.
  localparam int unsigned PEAK_BIN_W   = 12;
  localparam int unsigned FREQ_W       = 36;
  localparam int unsigned PEAK_PWR_W   = 48;
  localparam int unsigned FRAME_W      = 60;
  localparam int unsigned OUT_FIELDS_W = PEAK_BIN_W + FREQ_W + PEAK_PWR_W + FRAME_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TUSER_W  = 1;

endpackage

@@ rtl/core/spectral_peak_detector_unit.sv @@
// ---------------------------------------------------------------------------
// Spectral peak detector
// Finds the strongest bin of each spectrum frame and reports its index,
// frequency and power together with the frame power and a significance flag.
// ---------------------------------------------------------------------------
//
//  Channel     | Direction | Contents
//  ------------+-----------+-------------------------------------------------
//  s_axis      | in        | one complex spectrum bin per item
//  m_axis      | out       | one frame summary per item, after the last bin
//  cfg         | in        | register writes: frame length, ratio, bin step
//
// One bin is accepted every clock cycle while s_axis_tready is high. A frame
// summary appears on m_axis once the last bin of its frame has passed the
// five register stages: input, power, accumulate, products, result.
// Reset (rst_ni low) clears all valid flags, the bin counter and the frame
// state, and loads the register defaults. A stalled result only holds the
// pipeline once the stages behind it are full, so bins keep streaming in
// while a summary waits.
//
`include "spectral_peak_detector_unit_defines.svh"

module spectral_peak_detector_unit
  import spd_pkg::*;
#(
  parameter int unsigned MAX_BINS     = MAX_BINS_DEFAULT,
  parameter int unsigned SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_we_i,
  input  logic [CFG_IDX_W-1:0]              cfg_index_i,
  input  logic [CFG_DATA_W-1:0]             cfg_data_i,

  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Low to high: bin_real, bin_imag, zero fill to whole bytes.
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,

  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Low to high: peak_bin, peak_freq_q8, peak_power, frame_power, zero fill.
  output logic [OUT_TDATA_W-1:0]            m_axis_tdata,
  // Bit 0: significant.
  output logic [OUT_TUSER_W-1:0]            m_axis_tuser
);

  localparam int unsigned SW    = SAMPLE_WIDTH;
  // Magnitudes reach 2^(SW-1), so the sum of two squares fits in 2*SW bits.
  localparam int unsigned PWR_W = 2 * SAMPLE_WIDTH;
  localparam int unsigned CNT_W = $clog2(MAX_BINS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_BINS);
  localparam int unsigned TWO_W = CNT_W + 1;
  localparam int unsigned PA_W  = PWR_W + TWO_W;
  localparam int unsigned PB_W  = FRAME_W + RATIO_W;
  localparam int unsigned CMP_W = (PA_W > PB_W) ? PA_W : PB_W;

  // -------------------------------------------------------------------------
  // Configuration registers
  // -------------------------------------------------------------------------
  logic [BINS_CFG_W-1:0] bins_q;
  logic [RATIO_W-1:0]    ratio_q;
  logic [STEP_W-1:0]     step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_q  <= BINS_RESET;
      ratio_q <= RATIO_RESET;
      step_q  <= STEP_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BINS_PER_FRAME:  bins_q  <= cfg_data_i[BINS_CFG_W-1:0];
        CFG_RATIO_THRESHOLD: ratio_q <= cfg_data_i[RATIO_W-1:0];
        CFG_BIN_STEP:        step_q  <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective frame length: zero counts as one, and it never exceeds MAX_BINS.
  logic [CNT_W-1:0] bins_eff;

  always_comb begin
    priority if (bins_q == '0) begin
      bins_eff = CNT_W'(1);
    end else if (32'(bins_q) > 32'(MAX_BINS)) begin
      bins_eff = CNT_W'(MAX_BINS);
    end else begin
      bins_eff = CNT_W'(bins_q);
    end
  end

  // -------------------------------------------------------------------------
  // Handshake chain. Each stage is ready when empty or when it moves on.
  // Only the last bin of a frame needs room in the product stages.
  // -------------------------------------------------------------------------
  logic s1_v_q, s2_v_q, f1_v_q, f2_v_q, m_v_q;
  logic s2_last_q;
  logic out_ready, f2_ready, f1_ready;
  logic s2_adv, s2_ready, s1_adv, s1_ready;
  logic f1_adv, f2_adv, in_fire, m_fire;

  assign out_ready = !m_v_q || m_axis_tready;
  assign f2_ready  = !f2_v_q || out_ready;
  assign f1_ready  = !f1_v_q || f2_ready;
  assign s2_adv    = s2_v_q && (!s2_last_q || f1_ready);
  assign s2_ready  = !s2_v_q || s2_adv;
  assign s1_adv    = s1_v_q && s2_ready;
  assign s1_ready  = !s1_v_q || s1_adv;
  assign f1_adv    = f1_v_q && f2_ready;
  assign f2_adv    = f2_v_q && out_ready;

  assign s_axis_tready = s1_ready;
  assign in_fire       = s_axis_tvalid && s1_ready;
  assign m_fire        = m_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      m_v_q  <= 1'b0;
    end else begin
      s1_v_q <= in_fire ? 1'b1 : (s1_adv ? 1'b0 : s1_v_q);
      s2_v_q <= s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_v_q);
      f1_v_q <= (s2_adv && s2_last_q) ? 1'b1 : (f1_adv ? 1'b0 : f1_v_q);
      f2_v_q <= f1_adv ? 1'b1 : (f2_adv ? 1'b0 : f2_v_q);
      m_v_q  <= f2_adv ? 1'b1 : (m_fire ? 1'b0 : m_v_q);
    end
  end

  // -------------------------------------------------------------------------
  // Stage 1: input register. The bin index and the end-of-frame mark are
  // settled here, against the frame length in force when the bin arrives.
  // A length lowered mid-frame ends the frame at the next bin.
  // -------------------------------------------------------------------------
  logic [IDX_W-1:0] cnt_q;
  logic [CNT_W-1:0] cnt_next;
  logic             last_in;

  assign cnt_next = CNT_W'(cnt_q) + CNT_W'(1);
  assign last_in  = (cnt_next >= bins_eff);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_fire) begin
      cnt_q <= last_in ? '0 : IDX_W'(cnt_next);
    end
  end

  logic [SW-1:0]    s1_re_q, s1_im_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic             s1_last_q;

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_re_q   <= s_axis_tdata[SW-1:0];
      s1_im_q   <= s_axis_tdata[2*SW-1:SW];
      s1_idx_q  <= cnt_q;
      s1_last_q <= last_in;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 2: bin power. Two independent squares of the magnitudes.
  // -------------------------------------------------------------------------
  logic [SW-1:0]    re_mag, im_mag;
  logic [PWR_W-1:0] sq_re, sq_im;
  logic [PWR_W-1:0] s2_pwr_q;
  logic [IDX_W-1:0] s2_idx_q;

  // The most negative sample negates to itself, which read unsigned is
  // exactly its magnitude.
  assign re_mag = s1_re_q[SW-1] ? (~s1_re_q + SW'(1)) : s1_re_q;
  assign im_mag = s1_im_q[SW-1] ? (~s1_im_q + SW'(1)) : s1_im_q;
  assign sq_re  = re_mag * re_mag;
  assign sq_im  = im_mag * im_mag;

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_pwr_q  <= sq_re + sq_im;
      s2_idx_q  <= s1_idx_q;
      s2_last_q <= s1_last_q;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 3: frame accumulation. Only a strictly greater power replaces the
  // peak, so ties keep the earlier bin. The total wraps at 60 bits. On the
  // last bin the updated values go to the snapshot and the state clears.
  // -------------------------------------------------------------------------
  logic [PWR_W-1:0]   best_q, best_nx;
  logic [IDX_W-1:0]   bidx_q, bidx_nx;
  logic [FRAME_W-1:0] total_q, total_nx;
  logic               better;

  assign better   = (s2_pwr_q > best_q);
  assign best_nx  = better ? s2_pwr_q : best_q;
  assign bidx_nx  = better ? s2_idx_q : bidx_q;
  assign total_nx = total_q + FRAME_W'(s2_pwr_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q  <= '0;
      bidx_q  <= '0;
      total_q <= '0;
    end else if (s2_adv) begin
      if (s2_last_q) begin
        best_q  <= '0;
        bidx_q  <= '0;
        total_q <= '0;
      end else begin
        best_q  <= best_nx;
        bidx_q  <= bidx_nx;
        total_q <= total_nx;
      end
    end
  end

  logic [PWR_W-1:0]   f1_best_q;
  logic [IDX_W-1:0]   f1_idx_q;
  logic [FRAME_W-1:0] f1_total_q;

  always_ff @(posedge clk_i) begin
    if (s2_adv && s2_last_q) begin
      f1_best_q  <= best_nx;
      f1_idx_q   <= bidx_nx;
      f1_total_q <= total_nx;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 4: products. Significance compares peak * 2 * bins against
  // total * ratio exactly; the peak frequency is the 12-bit index times the
  // bin step.
  // -------------------------------------------------------------------------
  logic [TWO_W-1:0]      two_bins;
  logic [PEAK_BIN_W-1:0] f1_bin;
  logic [PA_W-1:0]       f2_pa_q;
  logic [PB_W-1:0]       f2_pb_q;
  logic [FREQ_W-1:0]     f2_freq_q;
  logic [PWR_W-1:0]      f2_best_q;
  logic [PEAK_BIN_W-1:0] f2_bin_q;
  logic [FRAME_W-1:0]    f2_total_q;

  assign two_bins = {bins_eff, 1'b0};
  assign f1_bin   = PEAK_BIN_W'(f1_idx_q);

  always_ff @(posedge clk_i) begin
    if (f1_adv) begin
      f2_pa_q    <= PA_W'(f1_best_q) * PA_W'(two_bins);
      f2_pb_q    <= PB_W'(f1_total_q) * PB_W'(ratio_q);
      f2_freq_q  <= FREQ_W'(f1_bin) * FREQ_W'(step_q);
      f2_best_q  <= f1_best_q;
      f2_bin_q   <= f1_bin;
      f2_total_q <= f1_total_q;
    end
  end

  // -------------------------------------------------------------------------
  // Stage 5: result register.
  // -------------------------------------------------------------------------
  logic                  m_sig_d;
  logic                  m_sig_q;
  logic [PEAK_BIN_W-1:0] m_bin_q;
  logic [FREQ_W-1:0]     m_freq_q;
  logic [PEAK_PWR_W-1:0] m_pwr_q;
  logic [FRAME_W-1:0]    m_frame_q;

  assign m_sig_d = (CMP_W'(f2_pa_q) > CMP_W'(f2_pb_q));

  always_ff @(posedge clk_i) begin
    if (f2_adv) begin
      m_sig_q   <= m_sig_d;
      m_bin_q   <= f2_bin_q;
      m_freq_q  <= f2_freq_q;
      m_pwr_q   <= PEAK_PWR_W'(f2_best_q);
      m_frame_q <= f2_total_q;
    end
  end

  assign m_axis_tvalid = m_v_q;
  assign m_axis_tdata  = OUT_TDATA_W'({m_frame_q, m_pwr_q, m_freq_q, m_bin_q});
  assign m_axis_tuser  = OUT_TUSER_W'(m_sig_q);

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `SPD_ASSERT_ALWAYS(a_cnt_bound, 32'(cnt_q) < 32'(MAX_BINS), "bin counter past frame limit")
  `SPD_ASSERT_NEXT(a_frame_clear, s2_adv && s2_last_q, (best_q == '0) && (bidx_q == '0) && (total_q == '0), "frame state not cleared after last bin")
  `SPD_ASSERT_SAME(a_sig_nonzero, f2_adv && m_sig_d, f2_best_q != '0, "significant flag with zero peak")
  `SPD_ASSERT_SAME(a_out_source, $rose(m_v_q), $past(f2_v_q), "result appeared without a product stage entry")

endmodule
